// ===== rtl/pdm_pkg.sv =====
// Shared types and constants of the PWM period and duty meter.
// Used by pdm_div, pdm_ctrl and pwm_period_duty_meter; depends on nothing.
package pdm_pkg;

  // Capture count and configuration widths.
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned TPU_W     = 8;
  localparam int unsigned SNUM_W    = 32;
  localparam int unsigned SFAC_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  // Result field widths.
  localparam int unsigned PERIOD_US_W = 17;
  localparam int unsigned TIME_US_W   = 16;
  localparam int unsigned FREQ_W      = 28;
  localparam int unsigned DUTY_W      = 7;
  localparam int unsigned SPEED_W     = 32;

  localparam int unsigned PERIOD_W = COUNT_W + 1;

  // Stream widths: tdata padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_FIELDS_W =
      PERIOD_US_W + 2 * TIME_US_W + FREQ_W + DUTY_W + SPEED_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELDS_W;

  // Serial divider: 32-bit dividend, divisor up to period times factor.
  localparam int unsigned DIV_W     = 32;
  localparam int unsigned DIVS_W    = PERIOD_W + SFAC_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // Scale constants.
  localparam int unsigned MICROS_PER_S  = 1000000;
  localparam int unsigned MICROS_W      = 20;
  localparam int unsigned PERCENT_SCALE = 100;
  localparam int unsigned PERCENT_W     = 7;

  // Register reset values.
  localparam logic [TPU_W-1:0]  TPU_RST  = TPU_W'(12);
  localparam logic [SNUM_W-1:0] SNUM_RST = SNUM_W'(60000000);
  localparam logic [SFAC_W-1:0] SFAC_RST = SFAC_W'(120);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKS_PER_US = 2'd0,
    CFG_SPEED_NUM    = 2'd1,
    CFG_SPEED_FACTOR = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_PERIOD = 3'd0,
    OP_HIGH   = 3'd1,
    OP_LOW    = 3'd2,
    OP_FREQ   = 3'd3,
    OP_DUTY   = 3'd4,
    OP_SPEED  = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [PERIOD_US_W-1:0] period_us;
    logic [TIME_US_W-1:0]   high_us;
    logic [TIME_US_W-1:0]   low_us;
    logic [FREQ_W-1:0]      frequency_hz;
    logic [DUTY_W-1:0]      duty_percent;
    logic [SPEED_W-1:0]     speed_value;
    logic                   zero_period;
  } result_t;

endpackage

// ===== rtl/pdm_div.sv =====
// Bit-serial restoring divider: one quotient bit per clock cycle.
// Depends on pdm_pkg for widths and the request/response structs.
module pdm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pdm_pkg::div_req_t req_i,
  output pdm_pkg::div_rsp_t rsp_o
);
  import pdm_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVS_W-1:0]    rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIVS_W-1:0]    dvs_q, dvs_d;

  logic [DIVS_W:0]   shifted;
  logic [DIVS_W+1:0] diff;
  logic              fits;

  // The shifted remainder is one bit wider than the divisor; the extra top
  // bit of the difference is the borrow.
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = ~diff[DIVS_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/pdm_ctrl.sv =====
// Sequencer of the meter: edge state, high and low times, and the six
// divisions issued in turn to the serial divider. Depends on pdm_pkg.
module pdm_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cap_valid_i,
  input  logic [pdm_pkg::COUNT_W-1:0]  cap_ticks_i,
  output logic                         cap_ready_o,
  input  logic [pdm_pkg::TPU_W-1:0]    tpu_i,
  input  logic [pdm_pkg::SNUM_W-1:0]   snum_i,
  input  logic [pdm_pkg::SFAC_W-1:0]   sfac_i,
  input  logic                         out_free_i,
  output logic                         res_load_o,
  output pdm_pkg::result_t             res_o,
  output pdm_pkg::div_req_t            div_req_o,
  input  pdm_pkg::div_rsp_t            div_rsp_i
);
  import pdm_pkg::*;

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic                 edge_q, edge_d;
  logic [COUNT_W-1:0]   high_q, high_d;
  logic [COUNT_W-1:0]   low_q, low_d;
  logic [PERIOD_W-1:0]  period_q, period_d;
  result_t              res_q, res_d;

  logic [TPU_W-1:0]  tpu_eff;
  logic [SFAC_W-1:0] fac_eff;
  logic              accept;

  // A zero register value counts as one.
  assign tpu_eff = (tpu_i == '0) ? TPU_W'(1) : tpu_i;
  assign fac_eff = (sfac_i == '0) ? SFAC_W'(1) : sfac_i;

  assign cap_ready_o = (state_q == ST_IDLE);
  assign accept      = cap_valid_i && cap_ready_o;
  assign res_o       = res_q;

  // Operand selection; the products land in the divider's input registers.
  always_comb begin
    div_req_o.start    = 1'b0;
    div_req_o.dividend = '0;
    div_req_o.divisor  = '0;
    if (state_q == ST_ISSUE && period_q != '0) begin
      div_req_o.start = 1'b1;
    end
    case (op_q)
      OP_PERIOD: begin
        div_req_o.dividend = DIV_W'(period_q);
        div_req_o.divisor  = DIVS_W'(tpu_eff);
      end
      OP_HIGH: begin
        div_req_o.dividend = DIV_W'(high_q);
        div_req_o.divisor  = DIVS_W'(tpu_eff);
      end
      OP_LOW: begin
        div_req_o.dividend = DIV_W'(low_q);
        div_req_o.divisor  = DIVS_W'(tpu_eff);
      end
      OP_FREQ: begin
        div_req_o.dividend = DIV_W'(tpu_eff) * DIV_W'(MICROS_PER_S);
        div_req_o.divisor  = DIVS_W'(period_q);
      end
      OP_DUTY: begin
        div_req_o.dividend = DIV_W'(high_q) * DIV_W'(PERCENT_SCALE);
        div_req_o.divisor  = DIVS_W'(period_q);
      end
      OP_SPEED: begin
        div_req_o.dividend = DIV_W'(snum_i);
        div_req_o.divisor  = DIVS_W'(period_q) * DIVS_W'(fac_eff);
      end
      default: begin
        div_req_o.dividend = '0;
        div_req_o.divisor  = '0;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    edge_d     = edge_q;
    high_d     = high_q;
    low_d      = low_q;
    period_d   = period_q;
    res_d      = res_q;
    res_load_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          edge_d = ~edge_q;
          if (!edge_q) begin
            high_d   = cap_ticks_i;
            period_d = {1'b0, cap_ticks_i} + {1'b0, low_q};
          end else begin
            low_d    = cap_ticks_i;
            period_d = {1'b0, high_q} + {1'b0, cap_ticks_i};
          end
          op_d    = OP_PERIOD;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (period_q == '0) begin
          res_d             = '0;
          res_d.zero_period = 1'b1;
          state_d           = ST_OUT;
        end else begin
          res_d.zero_period = 1'b0;
          state_d           = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (div_rsp_i.done) begin
          case (op_q)
            OP_PERIOD: res_d.period_us    = div_rsp_i.quotient[PERIOD_US_W-1:0];
            OP_HIGH:   res_d.high_us      = div_rsp_i.quotient[TIME_US_W-1:0];
            OP_LOW:    res_d.low_us       = div_rsp_i.quotient[TIME_US_W-1:0];
            OP_FREQ:   res_d.frequency_hz = div_rsp_i.quotient[FREQ_W-1:0];
            OP_DUTY:   res_d.duty_percent = div_rsp_i.quotient[DUTY_W-1:0];
            default:   res_d.speed_value  = div_rsp_i.quotient[SPEED_W-1:0];
          endcase
          if (op_q == OP_SPEED) begin
            state_d = ST_OUT;
          end else begin
            op_d    = op_e'(op_q + 3'd1);
            state_d = ST_ISSUE;
          end
        end
      end
      ST_OUT: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_PERIOD;
      edge_q   <= 1'b0;
      high_q   <= '0;
      low_q    <= '0;
      period_q <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      edge_q   <= edge_d;
      high_q   <= high_d;
      low_q    <= low_d;
      period_q <= period_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// ===== rtl/pwm_period_duty_meter.sv =====
// Top level of the PWM period and duty meter: configuration registers,
// output register and stream ports. Depends on pdm_pkg, pdm_div, pdm_ctrl.
//
// Each input transfer carries one capture count, the timer ticks since the
// previous edge. Captures alternate between high time and low time,
// starting with high time after reset. Every capture yields one output
// transfer with the period, high and low times in microseconds, the
// frequency in Hz, the duty in percent and the speed figure; tuser flags a
// zero period, in which case all data fields are zero. The six quotients of
// a capture are computed one after another on a single bit-serial divider,
// each with a load step, one step per quotient bit and a hand-over step. A
// zero period skips the divider. The next capture is taken as soon as the
// sequencer is free, even while the previous result still waits in the
// output register. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must write it only while the block is idle, which
// the block itself does not enforce. A ticks_per_us or speed_tick_factor of
// zero is treated as one, and an unknown index is ignored.
module pwm_period_duty_meter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Capture input.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] captured_ticks
  input  logic [pdm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Result output.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [16:0] period_us, [32:17] high_us, [48:33] low_us,
  // [76:49] frequency_hz, [83:77] duty_percent, [115:84] speed_value,
  // [119:116] zero padding
  output logic [pdm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [0] zero_period
  output logic                             m_axis_tuser,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [pdm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pdm_pkg::CFG_DAT_W-1:0]    cfg_data_i
);
  import pdm_pkg::*;

  // Configuration registers.
  logic [TPU_W-1:0]  tpu_q;
  logic [SNUM_W-1:0] snum_q;
  logic [SFAC_W-1:0] sfac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q  <= TPU_RST;
      snum_q <= SNUM_RST;
      sfac_q <= SFAC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TICKS_PER_US: tpu_q  <= cfg_data_i[TPU_W-1:0];
        CFG_SPEED_NUM:    snum_q <= cfg_data_i[SNUM_W-1:0];
        CFG_SPEED_FACTOR: sfac_q <= cfg_data_i[SFAC_W-1:0];
        default: ;
      endcase
    end
  end

  div_req_t div_req;
  div_rsp_t div_rsp;
  result_t  res;
  logic     res_load;
  logic     out_free;

  // The output register can take a new result when empty or being drained.
  logic     out_valid_q;
  result_t  out_q;

  assign out_free = !out_valid_q || m_axis_tready;

  pdm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_valid_i (s_axis_tvalid),
    .cap_ticks_i (s_axis_tdata[COUNT_W-1:0]),
    .cap_ready_o (s_axis_tready),
    .tpu_i       (tpu_q),
    .snum_i      (snum_q),
    .sfac_i      (sfac_q),
    .out_free_i  (out_free),
    .res_load_o  (res_load),
    .res_o       (res),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.zero_period;
  assign m_axis_tdata  = {OUT_PAD_W'(0), out_q.speed_value, out_q.duty_percent,
                          out_q.frequency_hz, out_q.low_us, out_q.high_us,
                          out_q.period_us};

  // A result is only moved into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> out_free)
    else $error("result loaded over an unread output");

  // A new division is never started while the divider is still working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // A zero period carries all-zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("zero period with non-zero data");

  // The duty never exceeds one hundred percent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.duty_percent <= DUTY_W'(PERCENT_SCALE)))
    else $error("duty above one hundred percent");

  // A capture accepted now cannot produce a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !res_load)
    else $error("result loaded straight after a capture");

endmodule
